@@ src/rsgt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rsgt_pkg;

  localparam int STREAM_SLOTS_DEF = 4;
  localparam int SEQ_W   = 16;
  localparam int KEY_W   = 8;
  localparam int SIZE_W  = 11;
  localparam int LIMIT_W = 6;

  localparam logic [SIZE_W-1:0]  HEADER_BYTES  = 11'd12;
  localparam logic [LIMIT_W-1:0] GAP_LIMIT_RST = 6'd16;

  typedef enum logic [1:0] {
    KIND_REJECT  = 2'd0,
    KIND_LATE    = 2'd1,
    KIND_CONCEAL = 2'd2,
    KIND_DELIVER = 2'd3
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;       // latch the input item
    logic eval;          // table lookup, gap decision, table update
    logic emit_conceal;  // load a conceal result into the output register
    logic emit_final;    // load the closing result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;      // output register can take a result this cycle
    logic gap;           // packet needs conceal results
    logic rem_last;      // current conceal result is the last one
  } stat_t;

endpackage
`default_nettype wire

@@ src/rsgt_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface rsgt_pkt_if;
  logic                        valid;
  logic                        ready;
  logic [rsgt_pkg::KEY_W-1:0]  stream_key;
  logic [rsgt_pkg::SEQ_W-1:0]  rtp_seq;
  logic [rsgt_pkg::SIZE_W-1:0] packet_size;

  modport source (output valid, stream_key, rtp_seq, packet_size, input ready);
  modport sink   (input valid, stream_key, rtp_seq, packet_size, output ready);
endinterface

interface rsgt_res_if;
  logic                       valid;
  logic                       ready;
  rsgt_pkg::kind_t            kind;
  logic [rsgt_pkg::SEQ_W-1:0] missing_seq;
  logic                       last;

  modport source (output valid, kind, missing_seq, last, input ready);
  modport sink   (input valid, kind, missing_seq, last, output ready);
endinterface
`default_nettype wire

@@ src/rsgt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rsgt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rsgt_pkg::stat_t stat,
  output rsgt_pkg::cmd_t       cmd
);
  import rsgt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_EVAL    = 4'b0010,
    S_CONCEAL = 4'b0100,
    S_FINAL   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.gap ? S_CONCEAL : S_FINAL;
      end
      S_CONCEAL: begin
        if (stat.out_free) begin
          cmd.emit_conceal = 1'b1;
          if (stat.rem_last) begin
            state_next = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        // next packet may be taken in the same cycle the closing result is loaded
        in_ready = stat.out_free;
        if (stat.out_free) begin
          cmd.emit_final = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_next  = S_EVAL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/rsgt_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rsgt_dp #(
  parameter int SLOTS = rsgt_pkg::STREAM_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [rsgt_pkg::LIMIT_W-1:0] cfg_data,
  input  wire logic [rsgt_pkg::KEY_W-1:0]   in_key,
  input  wire logic [rsgt_pkg::SEQ_W-1:0]   in_seq,
  input  wire logic [rsgt_pkg::SIZE_W-1:0]  in_size,
  input  wire rsgt_pkg::cmd_t               cmd,
  output rsgt_pkg::stat_t                   stat,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output rsgt_pkg::kind_t                   out_kind,
  output logic [rsgt_pkg::SEQ_W-1:0]        out_seq,
  output logic                              out_last
);
  import rsgt_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [LIMIT_W-1:0] gap_limit;

  // captured packet
  logic [KEY_W-1:0]  cap_key;
  logic [SEQ_W-1:0]  cap_seq;
  logic [SIZE_W-1:0] cap_size;

  // stream table
  logic [SLOTS-1:0]  slot_used;
  logic [KEY_W-1:0]  slot_key      [SLOTS];
  logic [SEQ_W-1:0]  slot_last_seq [SLOTS];

  // conceal walk
  logic [SEQ_W-1:0]   miss_ptr;
  logic [LIMIT_W-1:0] remaining;
  kind_t              final_kind;

  // lookup and decision
  logic              hit, free_found, short_pkt, late, gap, upd;
  logic [SLOT_W-1:0] hit_idx, free_idx, upd_idx;
  logic [SEQ_W-1:0]  expected, diff;
  kind_t             kind_dec;
  logic              emit;

  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == cap_key) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!slot_used[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  assign short_pkt = cap_size < HEADER_BYTES;
  assign expected  = slot_last_seq[hit_idx] + SEQ_W'(1);
  assign diff      = cap_seq - expected;
  assign late      = hit && diff[SEQ_W-1];
  assign gap       = !short_pkt && hit && !late && (diff != '0)
                     && (diff <= {{(SEQ_W-LIMIT_W){1'b0}}, gap_limit});
  assign upd       = cmd.eval && !short_pkt && !late && (hit || free_found);
  assign upd_idx   = hit ? hit_idx : free_idx;

  always_comb begin
    if (short_pkt) begin
      kind_dec = KIND_REJECT;
    end else if (late) begin
      kind_dec = KIND_LATE;
    end else begin
      kind_dec = KIND_DELIVER;
    end
  end

  assign emit          = cmd.emit_conceal || cmd.emit_final;
  assign stat.out_free = !out_valid || out_ready;
  assign stat.gap      = gap;
  assign stat.rem_last = remaining == LIMIT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= GAP_LIMIT_RST;
      slot_used <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        gap_limit <= cfg_data;
      end
      if (upd) begin
        slot_used[upd_idx] <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_key  <= in_key;
      cap_seq  <= in_seq;
      cap_size <= in_size;
    end
    if (upd) begin
      slot_key[upd_idx]      <= cap_key;
      slot_last_seq[upd_idx] <= cap_seq;
    end
    if (cmd.eval) begin
      miss_ptr   <= expected;
      remaining  <= diff[LIMIT_W-1:0];
      final_kind <= kind_dec;
    end else if (cmd.emit_conceal) begin
      miss_ptr  <= miss_ptr + SEQ_W'(1);
      remaining <= remaining - LIMIT_W'(1);
    end
    if (cmd.emit_conceal) begin
      out_kind <= KIND_CONCEAL;
      out_seq  <= miss_ptr;
      out_last <= 1'b0;
    end else if (cmd.emit_final) begin
      out_kind <= final_kind;
      out_seq  <= cap_seq;
      out_last <= 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ src/rtp_sequence_gap_tracker.sv @@
// RTP sequence gap tracker.
// pkt_in (sink): one packet per transfer - stream_key, rtp_seq, packet_size.
// res_out (source): result transfers - kind, missing_seq, last. Every packet
//   produces at least one result; last marks its closing result.
// cfg_we / cfg_data: writes gap_limit (reset 16); write only while idle.
// Flow: a packet is captured, evaluated against the stream table (lookup,
//   wrapped distance, table update), then its results go out through a
//   single output register, one per cycle while res_out.ready is high.
// Pacing: one packet at a time; a gap of N adds N conceal results. The next
//   packet is taken in the cycle the closing result is loaded.
// Stall: when res_out.ready is low the output register holds and the
//   controller waits; pkt_in.ready drops until results drain.
// Reset (rst, synchronous): clears the stream table valid bits, the
//   output register and the controller; gap_limit returns to 16.
`timescale 1ns / 1ps
`default_nettype none
module rtp_sequence_gap_tracker #(
  parameter int STREAM_SLOTS = rsgt_pkg::STREAM_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [rsgt_pkg::LIMIT_W-1:0] cfg_data,
  rsgt_pkt_if.sink                          pkt_in,
  rsgt_res_if.source                        res_out
);
  import rsgt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing: capture -> evaluate -> conceal burst -> closing result
  rsgt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pkt_in.valid),
    .in_ready (pkt_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stream table, gap arithmetic and the output register
  rsgt_dp #(
    .SLOTS (STREAM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_key    (pkt_in.stream_key),
    .in_seq    (pkt_in.rtp_seq),
    .in_size   (pkt_in.packet_size),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_kind  (res_out.kind),
    .out_seq   (res_out.missing_seq),
    .out_last  (res_out.last)
  );

endmodule
`default_nettype wire

@@ src/rsgt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rsgt_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire rsgt_pkg::kind_t            out_kind,
  input wire logic [rsgt_pkg::SEQ_W-1:0] out_seq,
  input wire logic                       out_last
);
  import rsgt_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_seq)
                                && $stable(out_last))
    else $error("result changed while stalled");

  // only conceal results are non-final
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_kind != KIND_CONCEAL)))
    else $error("last flag does not match kind");

  // one packet at a time: evaluation cycle follows every input transfer
  a_one_pkt: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken during evaluation");

  // output register empty after reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rtp_sequence_gap_tracker rsgt_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pkt_in.valid),
  .in_ready  (pkt_in.ready),
  .out_valid (res_out.valid),
  .out_ready (res_out.ready),
  .out_kind  (res_out.kind),
  .out_seq   (res_out.missing_seq),
  .out_last  (res_out.last)
);
`default_nettype wire

@@ verif/rtp_sequence_gap_tracker_checker.sv @@
`timescale 1ns / 1ps
// Watches both channels and the gap_limit port, keeps its own copy of the
// stream table, and compares every result transfer against the queue of
// predicted results.
module rtp_sequence_gap_tracker_checker #(
  parameter int SLOTS = rsgt_pkg::STREAM_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [rsgt_pkg::LIMIT_W-1:0] cfg_data,
  rsgt_pkt_if                               pkt,
  rsgt_res_if                               res,
  output int                                mismatches,
  output int                                outstanding,
  output int                                packets_seen,
  output int                                results_seen,
  output int                                conceal_seen,
  output int                                late_seen,
  output int                                reject_seen
);
  import rsgt_pkg::*;

  typedef struct packed {
    kind_t            kind;
    logic [SEQ_W-1:0] seq;
    logic             last;
  } result_t;

  result_t pending_results[$];

  logic               slot_used [SLOTS];
  logic [KEY_W-1:0]   slot_key  [SLOTS];
  logic [SEQ_W-1:0]   slot_last [SLOTS];
  logic [LIMIT_W-1:0] gap_limit;

  initial begin
    mismatches   = 0;
    packets_seen = 0;
    results_seen = 0;
    conceal_seen = 0;
    late_seen    = 0;
    reject_seen  = 0;
  end

  assign outstanding = pending_results.size();

  function automatic result_t make_result(kind_t kind, logic [SEQ_W-1:0] seq, logic last);
    result_t r;
    r.kind = kind;
    r.seq  = seq;
    r.last = last;
    return r;
  endfunction

  // Queue the results one packet causes and update the stream table.
  task automatic predict_packet(input logic [KEY_W-1:0] key, input logic [SEQ_W-1:0] seq,
                                input logic [SIZE_W-1:0] size);
    int               hit  = -1;
    int               free = -1;
    logic [SEQ_W-1:0] next_seq;
    logic [SEQ_W-1:0] delta;
    packets_seen++;
    if (size < HEADER_BYTES) begin
      pending_results.push_back(make_result(KIND_REJECT, seq, 1'b1));
      reject_seen++;
      return;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0) begin
        if (slot_used[i] && slot_key[i] == key) hit = i;
        else if (free < 0 && !slot_used[i]) free = i;
      end
    end
    if (hit >= 0) begin
      next_seq = slot_last[hit] + 16'd1;
      delta    = seq - next_seq;
      if (delta[SEQ_W-1]) begin
        pending_results.push_back(make_result(KIND_LATE, seq, 1'b1));
        late_seen++;
        return;
      end
      if (delta != 0 && delta <= {10'd0, gap_limit}) begin
        for (int d = 0; d < int'(delta); d++) begin
          pending_results.push_back(make_result(KIND_CONCEAL, next_seq + SEQ_W'(d), 1'b0));
          conceal_seen++;
        end
      end
      slot_last[hit] = seq;
    end else if (free >= 0) begin
      slot_used[free] = 1'b1;
      slot_key[free]  = key;
      slot_last[free] = seq;
    end
    pending_results.push_back(make_result(KIND_DELIVER, seq, 1'b1));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      gap_limit = GAP_LIMIT_RST;
      for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_we) gap_limit = cfg_data;

      if (res.valid && res.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result kind=%0d seq=%h last=%0b",
                     $realtime, res.kind, res.missing_seq, res.last);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (res.kind !== want.kind || res.missing_seq !== want.seq ||
              res.last !== want.last) begin
            if (mismatches < 10)
              $display("%0t: mismatch exp kind=%0d seq=%h last=%0b, got kind=%0d seq=%h last=%0b",
                       $realtime, want.kind, want.seq, want.last,
                       res.kind, res.missing_seq, res.last);
            mismatches++;
          end
        end
      end

      if (pkt.valid && pkt.ready)
        predict_packet(pkt.stream_key, pkt.rtp_seq, pkt.packet_size);
    end
  end

endmodule

@@ verif/rtp_sequence_gap_tracker_tb.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for the RTP sequence gap tracker. The checker next to
// the block does all prediction and comparison; this module only drives
// packets, the result-side ready, the gap_limit port, and decides pass/fail.
module rtp_sequence_gap_tracker_tb;
  import rsgt_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int PHASE_ITEMS  = 24;
  localparam int END_DRAIN    = 10;

  // Four streams that end up owning the four table slots. Chosen so every
  // key bit is seen at both levels.
  localparam logic [KEY_W-1:0] TRACKED_KEY [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_data;

  rsgt_pkt_if pkt_ch ();
  rsgt_res_if res_ch ();

  int mismatches, outstanding;
  int packets_seen, results_seen, conceal_seen, late_seen, reject_seen;
  int cycle_count;
  int settings_used;

  // Knobs for the random idling on each side; flipped per phase so some
  // stretches run back to back with no gaps at all.
  bit idle_on;
  bit stall_on;
  int stall_left;

  // gap_limit as last written, and a rough view of each tracked stream's
  // last sequence number so random packets land near the expected one.
  logic [LIMIT_W-1:0] cur_limit;
  logic [SEQ_W-1:0]   hint_seq   [4];
  bit                 hint_known [4];

  rtp_sequence_gap_tracker u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .pkt_in  (pkt_ch),
    .res_out (res_ch)
  );

  rtp_sequence_gap_tracker_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .pkt         (pkt_ch),
    .res         (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .packets_seen(packets_seen),
    .results_seen(results_seen),
    .conceal_seen(conceal_seen),
    .late_seen   (late_seen),
    .reject_seen (reject_seen)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Hard stop if the block hangs or a predicted result never shows up.
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d results still owed", cycle_count, outstanding);
    $display("rtp_sequence_gap_tracker test failed");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result-side backpressure, changed at the falling edge only.
  initial begin
    res_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        if (stall_on) stall_left = pick_idle();
      end
    end
  end

  // One packet transfer. Entered at a falling edge; returns at a falling
  // edge with valid either still high (next packet follows straight on) or
  // already dropped after an idle gap.
  task automatic send_pkt(input logic [KEY_W-1:0] key, input logic [SEQ_W-1:0] seq,
                          input logic [SIZE_W-1:0] size);
    int               gap;
    logic [SEQ_W-1:0] delta;
    pkt_ch.valid       <= 1'b1;
    pkt_ch.stream_key  <= key;
    pkt_ch.rtp_seq     <= seq;
    pkt_ch.packet_size <= size;
    do @(posedge clk); while (!pkt_ch.ready);
    @(negedge clk);
    // Follow the stream the way the block would, but only for steering the
    // random sequence numbers; late packets leave the hint alone.
    for (int i = 0; i < 4; i++) begin
      if (key == TRACKED_KEY[i] && size >= HEADER_BYTES) begin
        delta = seq - hint_seq[i] - 16'd1;
        if (!hint_known[i] || !delta[SEQ_W-1]) hint_seq[i] = seq;
        hint_known[i] = 1'b1;
      end
    end
    gap = idle_on ? pick_idle() : 0;
    if (gap > 0) begin
      pkt_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has gone out, plus a
  // few cycles of slack for the output register.
  task automatic drain();
    pkt_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // gap_limit may only change while the block is idle.
  task automatic write_gap_limit(input logic [LIMIT_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_limit  = value;
    settings_used++;
  endtask

  // Mostly well-formed traffic on the tracked streams: in order, small gaps
  // around the current limit, late/duplicate packets, big jumps, plus a few
  // packets of unknown streams and a few runts.
  task automatic send_random_pkt();
    int               r;
    int               idx;
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] next_seq;
    logic [SEQ_W-1:0] seq;
    logic [SIZE_W-1:0] size;
    r = $urandom_range(0, 99);
    if (r < 88) begin
      idx      = $urandom_range(0, 3);
      key      = TRACKED_KEY[idx];
      next_seq = hint_seq[idx] + 16'd1;
    end else begin
      key      = KEY_W'($urandom);
      next_seq = SEQ_W'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 45)      seq = next_seq;
    else if (r < 75) seq = next_seq + SEQ_W'($urandom_range(1, int'(cur_limit) + 2));
    else if (r < 87) seq = next_seq - SEQ_W'($urandom_range(1, 40));
    else if (r < 92) seq = next_seq + 16'h8000;  // furthest behind: still late
    else             seq = next_seq + SEQ_W'($urandom_range(64, 16'h7FFF));
    r = $urandom_range(0, 99);
    if (r < 8)       size = SIZE_W'($urandom_range(0, 11));
    else if (r < 12) size = 11'd2047;
    else             size = SIZE_W'($urandom_range(12, 2047));
    send_pkt(key, seq, size);
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    pkt_ch.valid       = 1'b0;
    pkt_ch.stream_key  = '0;
    pkt_ch.rtp_seq     = '0;
    pkt_ch.packet_size = '0;
    idle_on            = 1'b1;
    stall_on           = 1'b1;
    cur_limit          = GAP_LIMIT_RST;
    settings_used      = 1;
    for (int i = 0; i < 4; i++) begin
      hint_seq[i]   = '0;
      hint_known[i] = 1'b0;
    end

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, gap_limit at its reset value of 16.
    send_pkt(8'h00, 16'h0000, 11'd0);     // runt, zero length
    send_pkt(8'h00, 16'hFFFF, 11'd11);    // runt, one byte short of a header
    send_pkt(8'h00, 16'hFFFF, 11'd12);    // new stream at the size floor
    send_pkt(8'h00, 16'h0000, 11'd2047);  // in order across the wrap, max size
    send_pkt(8'h00, 16'h0000, 11'd100);   // duplicate -> late
    send_pkt(8'h00, 16'h0003, 11'd64);    // two missing
    send_pkt(8'h00, 16'h0014, 11'd200);   // gap exactly at the limit
    send_pkt(8'h00, 16'h0026, 11'd300);   // one past the limit: resync only
    send_pkt(8'hFF, 16'h8000, 11'd1500);  // new streams fill the table
    send_pkt(8'h5A, 16'h1234, 11'd12);
    send_pkt(8'hA5, 16'hFFFE, 11'd40);
    send_pkt(8'h33, 16'h0777, 11'd80);    // table full: delivered untracked
    send_pkt(8'h33, 16'h0777, 11'd80);    // still untracked, no late drop
    send_pkt(8'hFF, 16'h0000, 11'd90);    // furthest ahead (0x7FFF): resync
    send_pkt(8'hFF, 16'h8001, 11'd90);    // 0x8000 away: reads as behind
    send_pkt(8'hA5, 16'h0002, 11'd60);    // conceal across the 16-bit wrap
    send_pkt(8'h5A, 16'h1235, 11'd5);     // runt on a tracked stream
    send_pkt(8'h5A, 16'h1236, 11'd2047);  // single missing packet
    send_pkt(8'h00, 16'h0025, 11'd12);    // behind by two

    // Random phases, each under its own gap_limit: both extremes, zero
    // (never conceal) and a couple of values in between.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       write_gap_limit(6'd63);
        1:       write_gap_limit(6'd1);
        2:       write_gap_limit(6'd0);
        5:       write_gap_limit(6'd16);
        default: write_gap_limit(LIMIT_W'($urandom_range(2, 62)));
      endcase
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) send_random_pkt();
    end

    drain();
    repeat (END_DRAIN) @(negedge clk);

    $display("covered %0d packets under %0d gap_limit settings in %0d cycles",
             packets_seen, settings_used, cycle_count);
    $display("%0d results checked: %0d conceal, %0d late, %0d runt, %0d mismatches",
             results_seen, conceal_seen, late_seen, reject_seen, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("rtp_sequence_gap_tracker test passed");
    else
      $display("rtp_sequence_gap_tracker test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/rsgt_pkg.sv
src/rsgt_if.sv
src/rsgt_ctrl.sv
src/rsgt_dp.sv
src/rtp_sequence_gap_tracker.sv
src/rsgt_checker.sv
verif/rtp_sequence_gap_tracker_checker.sv
verif/rtp_sequence_gap_tracker_tb.sv
